@@ hw/rtl/sfr_pkg.sv @@
// Shared types and constants for the servo bus packet framer.
package sfr_pkg;

    // Input word kinds carried on s_tuser.
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_PAYLOAD = 1'b1;

    // Status codes reported with each output word.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_LEN_ERR = 2'd1;
    localparam logic [1:0] STATUS_ORPHAN  = 2'd2;

    // Packet constants.
    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [7:0] MAX_LEN  = 8'd254;

    // Byte positions within a packet, as walked by the back end.
    localparam logic [2:0] STEP_SYNC0 = 3'd0;
    localparam logic [2:0] STEP_SYNC1 = 3'd1;
    localparam logic [2:0] STEP_ID    = 3'd2;
    localparam logic [2:0] STEP_LEN   = 3'd3;
    localparam logic [2:0] STEP_DATA  = 3'd4;
    localparam logic [2:0] STEP_CKSUM = 3'd5;

    // One classified command handed from the front end to the back end.
    typedef struct packed {
        logic [1:0] status;
        logic       is_header;
        logic       with_cksum;
        logic [7:0] id;
        logic [7:0] len2;
        logic [7:0] data;
        logic [7:0] cksum;
    } cmd_t;

endpackage

@@ hw/rtl/servo_bus_packet_framer_core.sv @@
// Servo bus packet framer top level: front end, command queue and back end.
// An accepted word is queued; its bytes then leave through the output register.
// Throughput: one input word per cycle while the queue has room; the back end sends
// one byte per cycle unless the output is stalled, so a start word takes five or six
// bytes (one on a length error), a payload word one, or two if the checksum follows.
// Reset: rst_n clears packet state, queue and output register asynchronously.
module servo_bus_packet_framer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // packet_id, packet_type, payload_length, payload_byte
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic [2:0]  m_tuser,   // status[1:0], run_last[2]
    output logic        m_tlast    // packet_last
);

    sfr_pkg::cmd_t push_cmd, head;
    logic          push, pop, empty, full;

    sfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (full),
        .push     (push),
        .cmd      (push_cmd)
    );

    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    sfr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hw/rtl/sfr_front.sv @@
// Front end: accepts input words, tracks packet state and classifies them into commands.
module sfr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,   // packet_id, packet_type, payload_length, payload_byte
    input  logic          s_tuser,   // mode
    input  logic          q_full,
    output logic          push,
    output sfr_pkg::cmd_t cmd
);

    logic       open_reg, open_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] sum_reg, sum_next;

    logic [7:0] f_id, f_type, f_len, f_byte;
    logic [7:0] len2, hdr_sum, pay_sum;
    logic       accept;

    assign f_id   = s_tdata[7:0];
    assign f_type = s_tdata[15:8];
    assign f_len  = s_tdata[23:16];
    assign f_byte = s_tdata[31:24];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept;

    assign len2    = f_len + 8'd2;
    assign hdr_sum = f_id + len2 + f_type;
    assign pay_sum = sum_reg + f_byte;

    // Classify the word and compute the next packet state.
    always_comb
    begin
        open_next      = open_reg;
        left_next      = left_reg;
        sum_next       = sum_reg;
        cmd.status     = sfr_pkg::STATUS_OK;
        cmd.is_header  = 1'b0;
        cmd.with_cksum = 1'b0;
        cmd.id         = f_id;
        cmd.len2       = len2;
        cmd.data       = 8'd0;
        cmd.cksum      = ~hdr_sum;
        if (s_tuser == sfr_pkg::MODE_START)
        begin
            open_next = 1'b0;
            left_next = 8'd0;
            sum_next  = 8'd0;
            if (f_len > sfr_pkg::MAX_LEN)
            begin
                cmd.status = sfr_pkg::STATUS_LEN_ERR;
            end
            else
            begin
                cmd.is_header = 1'b1;
                cmd.data      = f_type;
                if (f_len == 8'd0)
                begin
                    cmd.with_cksum = 1'b1;
                end
                else
                begin
                    open_next = 1'b1;
                    left_next = f_len;
                    sum_next  = hdr_sum;
                end
            end
        end
        else if (!open_reg)
        begin
            cmd.status = sfr_pkg::STATUS_ORPHAN;
        end
        else
        begin
            cmd.data  = f_byte;
            cmd.cksum = ~pay_sum;
            left_next = left_reg - 8'd1;
            if (left_reg == 8'd1)
            begin
                cmd.with_cksum = 1'b1;
                open_next      = 1'b0;
                sum_next       = 8'd0;
            end
            else
            begin
                sum_next = pay_sum;
            end
        end
    end

    // Packet state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            left_reg <= 8'd0;
            sum_reg  <= 8'd0;
        end
        else if (accept)
        begin
            open_reg <= open_next;
            left_reg <= left_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

@@ hw/rtl/sfr_queue.sv @@
// Short command queue between the front end and the back end.
module sfr_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfr_pkg::cmd_t push_cmd,
    input  logic          pop,
    output sfr_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sfr_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    // Entry storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count, wrapping at any depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

@@ hw/rtl/sfr_back.sv @@
// Back end: expands commands into wire bytes behind an output register.
module sfr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  sfr_pkg::cmd_t head,
    input  logic          empty,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // out_byte
    output logic [2:0]    m_tuser,   // status[1:0], run_last[2]
    output logic          m_tlast    // packet_last
);

    sfr_pkg::cmd_t cmd_reg, cur;
    logic          busy_reg, busy_next;
    logic [2:0]    step_reg, cur_step;
    logic          m_tvalid_reg;
    logic [7:0]    m_tdata_reg;
    logic [2:0]    m_tuser_reg;
    logic          m_tlast_reg;
    logic          load_ok, emit, is_last;
    logic [7:0]    byte_sel;

    // Current command comes from the holding register or straight from the queue head.
    assign load_ok  = !m_tvalid_reg || m_tready;
    assign cur      = busy_reg ? cmd_reg : head;
    assign cur_step = busy_reg ? step_reg :
                      (head.is_header ? sfr_pkg::STEP_SYNC0 : sfr_pkg::STEP_DATA);
    assign emit     = load_ok && (busy_reg || !empty);
    assign is_last  = (cur_step == (cur.with_cksum ? sfr_pkg::STEP_CKSUM : sfr_pkg::STEP_DATA));
    assign pop      = emit && !busy_reg;
    assign busy_next = !is_last;

    // Byte at the current position of the packet.
    always_comb
    begin
        case (cur_step)
            sfr_pkg::STEP_SYNC0, sfr_pkg::STEP_SYNC1: byte_sel = sfr_pkg::HDR_BYTE;
            sfr_pkg::STEP_ID:    byte_sel = cur.id;
            sfr_pkg::STEP_LEN:   byte_sel = cur.len2;
            sfr_pkg::STEP_DATA:  byte_sel = cur.data;
            sfr_pkg::STEP_CKSUM: byte_sel = cur.cksum;
            default:             byte_sel = 8'd0;
        endcase
    end

    // Command holding register, loaded from the queue head on each pop.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
    end

    // Walk state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            step_reg     <= sfr_pkg::STEP_SYNC0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= 8'd0;
            m_tuser_reg  <= 3'd0;
            m_tlast_reg  <= 1'b0;
        end
        else if (load_ok)
        begin
            m_tvalid_reg <= emit;
            if (emit)
            begin
                busy_reg    <= busy_next;
                step_reg    <= cur_step + 3'd1;
                m_tdata_reg <= byte_sel;
                m_tuser_reg <= {is_last, cur.status};
                m_tlast_reg <= (cur_step == sfr_pkg::STEP_CKSUM);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ hw/rtl/sfr_checker.sv @@
// Port-level checks for the servo bus packet framer, bound to the top level.
module sfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled output word holds its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    // The checksum byte always ends the run of its input word.
    a_cksum_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[2] && (m_tuser[1:0] == sfr_pkg::STATUS_OK))
        else $error("checksum byte without run end");

    // An error word is a lone zero byte.
    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] != sfr_pkg::STATUS_OK)
            |-> (m_tdata == 8'd0) && m_tuser[2] && !m_tlast)
        else $error("malformed error word");

    // Only defined status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1:0] == sfr_pkg::STATUS_OK)
            || (m_tuser[1:0] == sfr_pkg::STATUS_LEN_ERR)
            || (m_tuser[1:0] == sfr_pkg::STATUS_ORPHAN))
        else $error("undefined status code");

endmodule

bind servo_bus_packet_framer_core sfr_checker u_sfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ dv/tb_servo_bus_packet_framer_core.sv @@
// Self-checking testbench for the servo bus packet framer core.
module tb_servo_bus_packet_framer_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ITEMS    = 500;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int GAP_PERCENT  = 21;
    localparam int CALM_FIRST   = 1000;
    localparam int CALM_LAST    = 1800;

    // One input word as the sender sees it.
    typedef struct packed {
        logic       mode;
        logic [7:0] pid;
        logic [7:0] ptype;
        logic [7:0] plen;
        logic [7:0] pbyte;
    } bus_word_t;

    // One byte expected on the wire, with its side-band flags.
    typedef struct packed {
        logic [7:0] value;
        logic [1:0] status;
        logic       run_last;
        logic       packet_last;
    } wire_byte_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // packet_id, packet_type, payload_length, payload_byte
    logic        s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte
    logic [2:0]  m_tuser;   // status[1:0], run_last[2]
    logic        m_tlast;   // packet_last

    bus_word_t  pending_words[$];
    wire_byte_t wire_bytes[$];
    bus_word_t  next_word;
    wire_byte_t got_byte;
    wire_byte_t want_byte;

    // Framer state as predicted by the testbench.
    logic       pkt_open;
    logic [7:0] bytes_left;
    logic [7:0] cksum_sum;

    int  err_count;
    int  cyc;
    int  quiet;
    logic calm;

    servo_bus_packet_framer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign calm = (cyc >= CALM_FIRST) && (cyc < CALM_LAST);

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic push_wire_byte(input logic [7:0] value, input logic [1:0] status,
                                  input logic run_last, input logic packet_last);
        wire_byte_t b;
        b.value       = value;
        b.status      = status;
        b.run_last    = run_last;
        b.packet_last = packet_last;
        wire_bytes.push_back(b);
    endtask

    // Works out the wire bytes one accepted input word produces.
    task automatic frame_word(input logic mode, input logic [31:0] data);
        logic [7:0] pid;
        logic [7:0] ptype;
        logic [7:0] plen;
        logic [7:0] pbyte;
        logic [7:0] len2;
        pid   = data[7:0];
        ptype = data[15:8];
        plen  = data[23:16];
        pbyte = data[31:24];
        if (mode == sfr_pkg::MODE_START)
        begin
            // A start always drops whatever packet was open.
            pkt_open   = 1'b0;
            bytes_left = 8'd0;
            if (plen > sfr_pkg::MAX_LEN)
            begin
                cksum_sum = 8'd0;
                push_wire_byte(8'd0, sfr_pkg::STATUS_LEN_ERR, 1'b1, 1'b0);
            end
            else
            begin
                len2      = plen + 8'd2;
                cksum_sum = pid + len2 + ptype;
                push_wire_byte(sfr_pkg::HDR_BYTE, sfr_pkg::STATUS_OK, 1'b0, 1'b0);
                push_wire_byte(sfr_pkg::HDR_BYTE, sfr_pkg::STATUS_OK, 1'b0, 1'b0);
                push_wire_byte(pid, sfr_pkg::STATUS_OK, 1'b0, 1'b0);
                push_wire_byte(len2, sfr_pkg::STATUS_OK, 1'b0, 1'b0);
                if (plen == 8'd0)
                begin
                    push_wire_byte(ptype, sfr_pkg::STATUS_OK, 1'b0, 1'b0);
                    push_wire_byte(~cksum_sum, sfr_pkg::STATUS_OK, 1'b1, 1'b1);
                    cksum_sum = 8'd0;
                end
                else
                begin
                    push_wire_byte(ptype, sfr_pkg::STATUS_OK, 1'b1, 1'b0);
                    pkt_open   = 1'b1;
                    bytes_left = plen;
                end
            end
        end
        else if (!pkt_open)
        begin
            push_wire_byte(8'd0, sfr_pkg::STATUS_ORPHAN, 1'b1, 1'b0);
        end
        else
        begin
            cksum_sum  = cksum_sum + pbyte;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0)
            begin
                push_wire_byte(pbyte, sfr_pkg::STATUS_OK, 1'b0, 1'b0);
                push_wire_byte(~cksum_sum, sfr_pkg::STATUS_OK, 1'b1, 1'b1);
                pkt_open  = 1'b0;
                cksum_sum = 8'd0;
            end
            else
            begin
                push_wire_byte(pbyte, sfr_pkg::STATUS_OK, 1'b1, 1'b0);
            end
        end
    endtask

    // Sender: predicts on each accepted word, then offers the next one or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 32'd0;
            s_tuser    <= sfr_pkg::MODE_START;
            pkt_open   = 1'b0;
            bytes_left = 8'd0;
            cksum_sum  = 8'd0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                frame_word(s_tuser, s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0 &&
                    (calm || $urandom_range(99) >= GAP_PERCENT))
                begin
                    next_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_word.mode;
                    s_tdata  <= {next_word.pbyte, next_word.plen, next_word.ptype,
                                 next_word.pid};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= GAP_PERCENT);
    end

    // Output checker: each accepted byte against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_byte.value       = m_tdata;
            got_byte.status      = m_tuser[1:0];
            got_byte.run_last    = m_tuser[2];
            got_byte.packet_last = m_tlast;
            if (wire_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h", got_byte.value));
            end
            else
            begin
                want_byte = wire_bytes.pop_front();
                if (got_byte.value !== want_byte.value)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              got_byte.value, want_byte.value));
                if (got_byte.status !== want_byte.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              got_byte.status, want_byte.status));
                if (got_byte.run_last !== want_byte.run_last)
                    report_mismatch($sformatf("run_last %0b, want %0b",
                                              got_byte.run_last, want_byte.run_last));
                if (got_byte.packet_last !== want_byte.packet_last)
                    report_mismatch($sformatf("packet_last %0b, want %0b",
                                              got_byte.packet_last, want_byte.packet_last));
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc   <= 0;
            quiet <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet <= 0;
            end
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    task automatic add_start(input logic [7:0] pid, input logic [7:0] ptype,
                             input logic [7:0] plen, input logic [7:0] pbyte);
        bus_word_t w;
        w.mode  = sfr_pkg::MODE_START;
        w.pid   = pid;
        w.ptype = ptype;
        w.plen  = plen;
        w.pbyte = pbyte;
        pending_words.push_back(w);
    endtask

    task automatic add_payload(input logic [7:0] pbyte, input logic [23:0] unused);
        bus_word_t w;
        w.mode  = sfr_pkg::MODE_PAYLOAD;
        w.pid   = unused[7:0];
        w.ptype = unused[15:8];
        w.plen  = unused[23:16];
        w.pbyte = pbyte;
        pending_words.push_back(w);
    endtask

    task automatic add_random_start(input logic [7:0] plen);
        add_start(8'($urandom_range(255)), 8'($urandom_range(255)), plen,
                  8'($urandom_range(255)));
    endtask

    task automatic add_random_payloads(input int count);
        for (int i = 0; i < count; i++)
            add_payload(8'($urandom_range(255)), 24'($urandom));
    endtask

    // Stimulus and end of run.
    initial
    begin
        int pick;
        int plen;
        int part;
        logic big_done;
        err_count = 0;
        big_done  = 1'b0;
        rst_n     = 1'b0;

        // Directed: extremes, errors, orphans and abandoned packets.
        add_payload(8'h00, 24'h000000);
        add_start(8'h00, 8'h00, 8'd0, 8'h00);
        add_start(8'hFF, 8'hFF, 8'd0, 8'hFF);
        add_start(8'h12, 8'h34, 8'd255, 8'h00);
        add_payload(8'hFF, 24'hFFFFFF);
        add_start(8'h01, 8'h03, 8'd1, 8'h5A);
        add_payload(8'hAA, 24'hFFFFFF);
        add_start(8'hFE, 8'h02, 8'd3, 8'h00);
        add_payload(8'h01, 24'h000000);
        add_payload(8'h02, 24'h123456);
        add_start(8'h10, 8'h05, 8'd2, 8'hFF);
        add_payload(8'h55, 24'h000000);
        add_payload(8'h80, 24'hFFFFFF);
        add_start(8'h07, 8'h80, 8'd2, 8'h00);
        add_payload(8'h07, 24'h000000);
        add_start(8'hFF, 8'hFF, 8'd255, 8'hFF);
        add_payload(8'h33, 24'h000000);
        add_start(8'h80, 8'h7F, 8'd128, 8'h00);
        add_start(8'hFF, 8'h00, 8'd0, 8'h00);

        // Random: mostly whole packets, with broken ones and noise mixed in.
        while (pending_words.size() < NUM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (!big_done && pending_words.size() > 150)
            begin
                add_random_start(sfr_pkg::MAX_LEN);
                add_random_payloads(int'(sfr_pkg::MAX_LEN));
                big_done = 1'b1;
            end
            else if (pick < 70)
            begin
                plen = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
                add_random_start(8'(plen));
                add_random_payloads(plen);
            end
            else if (pick < 78)
            begin
                plen = $urandom_range(1, sfr_pkg::MAX_LEN);
                part = $urandom_range(0, (plen > 3) ? 3 : plen - 1);
                add_random_start(8'(plen));
                add_random_payloads(part);
            end
            else if (pick < 86)
            begin
                add_random_start(8'd255);
            end
            else
            begin
                add_random_payloads($urandom_range(1, 2));
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be taken and every byte to arrive.
        while (pending_words.size() != 0 || s_tvalid) @(posedge clk);
        while (wire_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_queue.sv
hw/rtl/sfr_back.sv
hw/rtl/servo_bus_packet_framer_core.sv
hw/rtl/sfr_checker.sv
dv/tb_servo_bus_packet_framer_core.sv
